### hw/rtl/pkrf_pkg.sv
// Package for the palette keypoint ramp fill block: sizes, opcodes, payload
// and control structs. No dependencies.
`default_nettype none

package pkrf_pkg;

	localparam int unsigned PALETTE_DEPTH = 256;
	localparam int unsigned IDX_W         = 8;
	localparam int unsigned COLOR_W       = 8;
	localparam int unsigned NUM_CH        = 3;
	localparam int unsigned RGB_W         = NUM_CH * COLOR_W;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic               op;
		logic [IDX_W-1:0]   key_index;
		logic [COLOR_W-1:0] key_red;
		logic [COLOR_W-1:0] key_green;
		logic [COLOR_W-1:0] key_blue;
	} key_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   entry_index;
		logic [COLOR_W-1:0] entry_red;
		logic [COLOR_W-1:0] entry_green;
		logic [COLOR_W-1:0] entry_blue;
	} entry_item_t;

	typedef struct packed {
		logic load_key;
		logic load_rd;
		logic wr_p;
		logic wr_j;
		logic div_init;
		logic div_step;
		logic fill_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic key_in_range;
		logic key_ge;
		logic span_gt1;
		logic div_last;
		logic fill_last;
	} sts_t;

endpackage

`default_nettype wire

### hw/rtl/pkrf_if.sv
// Valid/ready channel interfaces for keypoint/read transactions and palette
// entry results. Depends on pkrf_pkg.
`default_nettype none

interface pkrf_key_if;
	logic                valid;
	logic                ready;
	pkrf_pkg::key_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pkrf_entry_if;
	logic                  valid;
	logic                  ready;
	pkrf_pkg::entry_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/pkrf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while read enable is low. No dependencies.
`default_nettype none

module pkrf_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/pkrf_ctrl.sv
// Controller state machine: sequences keypoint writes, the per-channel
// slope division, the ramp fill and palette reads. Depends on pkrf_pkg.
`default_nettype none

module pkrf_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire logic           req_op,
	input  wire logic           rsp_ready,
	input  wire pkrf_pkg::sts_t sts,
	output pkrf_pkg::cmd_t      cmd,
	output logic                req_ready,
	output logic                rsp_valid
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_WR_P = 6'b000010,
		S_WR_J = 6'b000100,
		S_DIV  = 6'b001000,
		S_FILL = 6'b010000,
		S_READ = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   rsp_valid_q;

	always_comb begin
		cmd       = '0;
		state_nx  = state_q;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_op == pkrf_pkg::OP_READ) begin
						cmd.load_rd = 1'b1;
						state_nx    = S_READ;
					end else if (sts.key_in_range) begin
						cmd.load_key = 1'b1;
						state_nx     = S_WR_P;
					end
				end
			end
			S_WR_P: begin
				if (sts.key_ge) begin
					cmd.wr_p = 1'b1;
					state_nx = S_WR_J;
				end else begin
					state_nx = S_IDLE;
				end
			end
			S_WR_J: begin
				cmd.wr_j = 1'b1;
				if (sts.span_gt1) begin
					cmd.div_init = 1'b1;
					state_nx     = S_DIV;
				end else begin
					state_nx = S_IDLE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nx = S_FILL;
				end
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_nx = S_IDLE;
				end
			end
			S_READ: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

### hw/rtl/pkrf_dp.sv
// Datapath: keypoint registers, shared restoring divider for the per-channel
// slope, three ramp lanes, palette RAM and result register.
// Depends on pkrf_pkg and pkrf_ram.
`default_nettype none

module pkrf_dp #(
	parameter int unsigned PALETTE_DEPTH = pkrf_pkg::PALETTE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pkrf_pkg::cmd_t      cmd,
	input  wire pkrf_pkg::key_item_t key,
	output pkrf_pkg::sts_t           sts,
	output pkrf_pkg::entry_item_t    entry
);

	localparam int unsigned AW = $clog2(PALETTE_DEPTH);
	localparam int unsigned CW = pkrf_pkg::COLOR_W;
	localparam int unsigned IW = pkrf_pkg::IDX_W;
	localparam int unsigned NC = pkrf_pkg::NUM_CH;

	logic [NC-1:0][CW-1:0] prev_col_q;
	logic [IW-1:0]         prev_idx_q;
	logic [IW-1:0]         p_q;
	logic [IW-1:0]         j_q;
	logic [IW-1:0]         span_q;
	logic [NC-1:0][CW-1:0] s_q;
	logic [NC-1:0][CW-1:0] c_q;
	logic [IW-1:0]         rd_idx_q;
	logic                  rd_oor_q;

	logic [1:0]            ch_q;
	logic [2:0]            bit_q;
	logic [CW-1:0]         dvd_q;
	logic [CW-1:0]         pr_q;
	logic [CW-1:0]         quo_q;
	logic                  neg_q;
	logic [NC-1:0][CW-1:0] qd_q;
	logic [NC-1:0][CW:0]   rd2_q;
	logic [NC-1:0][CW-1:0] val_q;
	logic [NC-1:0][CW:0]   rem_q;
	logic [IW-1:0]         addr_q;
	pkrf_pkg::entry_item_t entry_q;

	logic [NC-1:0][CW-1:0] key_col;
	logic                  in_range;
	logic [1:0]            ld_ch;
	logic [CW:0]           ld_diff;
	logic [CW-1:0]         ld_mag;
	logic [CW:0]           trial;
	logic                  trial_ge;
	logic [CW-1:0]         pr_nx;
	logic [CW-1:0]         quo_nx;
	logic [CW-1:0]         qd_calc;
	logic [CW-1:0]         rd_calc;
	logic                  bit_last;
	logic                  div_last;
	logic [CW+1:0]         two_span;
	logic [NC-1:0][CW+1:0] fill_sum;
	logic [NC-1:0]         fill_ov;
	logic [NC-1:0][CW:0]   rem_nx;
	logic [NC-1:0][CW-1:0] val_nx;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [NC*CW-1:0]      ram_wdata;
	logic [NC*CW-1:0]      ram_rdata;

	assign key_col  = {key.key_red, key.key_green, key.key_blue};
	assign in_range = (32'(key.key_index) < 32'(PALETTE_DEPTH));

	// divider: |c - s| / span, one quotient bit per cycle
	assign ld_ch    = (cmd.div_init || ch_q == 2'd2) ? 2'd0 : 2'(ch_q + 2'd1);
	assign ld_diff  = {1'b0, c_q[ld_ch]} - {1'b0, s_q[ld_ch]};
	assign ld_mag   = ld_diff[CW] ? CW'(-ld_diff) : ld_diff[CW-1:0];
	assign trial    = {pr_q, dvd_q[CW-1]};
	assign trial_ge = (trial >= {1'b0, span_q});
	assign pr_nx    = trial_ge ? CW'(trial - {1'b0, span_q}) : trial[CW-1:0];
	assign quo_nx   = {quo_q[CW-2:0], trial_ge};
	assign bit_last = (bit_q == 3'd7);
	assign div_last = bit_last && (ch_q == 2'd2);

	// floor division for a negative difference
	always_comb begin
		if (neg_q && pr_nx != '0) begin
			qd_calc = ~quo_nx;
			rd_calc = span_q - pr_nx;
		end else if (neg_q) begin
			qd_calc = CW'(-quo_nx);
			rd_calc = '0;
		end else begin
			qd_calc = quo_nx;
			rd_calc = pr_nx;
		end
	end

	// ramp lanes: quotient steps by qd, remainder by 2*rd modulo 2*span
	assign two_span = {1'b0, span_q, 1'b0};
	always_comb begin
		for (int n = 0; n < NC; n++) begin
			fill_sum[n] = {1'b0, rem_q[n]} + {1'b0, rd2_q[n]};
			fill_ov[n]  = (fill_sum[n] >= two_span);
			rem_nx[n]   = fill_ov[n] ? (CW+1)'(fill_sum[n] - two_span) : fill_sum[n][CW:0];
			val_nx[n]   = val_q[n] + qd_q[n] + {{(CW-1){1'b0}}, fill_ov[n]};
		end
	end

	always_comb begin
		sts.key_in_range = in_range;
		sts.key_ge       = (p_q <= j_q);
		sts.span_gt1     = (span_q > 8'd1);
		sts.div_last     = div_last;
		sts.fill_last    = (addr_q == IW'(j_q - 8'd1));
	end

	always_comb begin
		ram_we = cmd.wr_p || cmd.wr_j || cmd.fill_step;
		if (cmd.wr_p) begin
			ram_waddr = AW'(p_q);
			ram_wdata = s_q;
		end else if (cmd.wr_j) begin
			ram_waddr = AW'(j_q);
			ram_wdata = c_q;
		end else begin
			ram_waddr = AW'(addr_q);
			ram_wdata = val_nx;
		end
	end

	pkrf_ram #(
		.WIDTH(NC * CW),
		.DEPTH(PALETTE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.load_rd && in_range),
		.raddr(AW'(key.key_index)),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_idx_q <= '0;
			prev_col_q <= '0;
			ch_q       <= '0;
			bit_q      <= '0;
			addr_q     <= '0;
		end else begin
			if (cmd.load_key) begin
				prev_idx_q <= key.key_index;
				prev_col_q <= key_col;
			end
			if (cmd.div_init || (cmd.div_step && bit_last && !div_last)) begin
				ch_q  <= ld_ch;
				bit_q <= '0;
			end else if (cmd.div_step) begin
				bit_q <= 3'(bit_q + 3'd1);
			end
			if (cmd.div_step && div_last) begin
				addr_q <= IW'(p_q + 8'd1);
			end else if (cmd.fill_step) begin
				addr_q <= IW'(addr_q + 8'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			p_q    <= prev_idx_q;
			s_q    <= prev_col_q;
			j_q    <= key.key_index;
			c_q    <= key_col;
			span_q <= IW'(key.key_index - prev_idx_q);
		end
		if (cmd.load_rd) begin
			rd_idx_q <= key.key_index;
			rd_oor_q <= !in_range;
		end
		if (cmd.div_init || (cmd.div_step && bit_last && !div_last)) begin
			dvd_q <= ld_mag;
			pr_q  <= '0;
			quo_q <= '0;
			neg_q <= ld_diff[CW];
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[CW-2:0], 1'b0};
			pr_q  <= pr_nx;
			quo_q <= quo_nx;
		end
		if (cmd.div_step && bit_last) begin
			qd_q[ch_q]  <= qd_calc;
			rd2_q[ch_q] <= {rd_calc, 1'b0};
		end
		if (cmd.div_step && div_last) begin
			for (int n = 0; n < NC; n++) begin
				val_q[n] <= s_q[n];
				rem_q[n] <= {1'b0, span_q};
			end
		end else if (cmd.fill_step) begin
			val_q <= val_nx;
			rem_q <= rem_nx;
		end
		if (cmd.out_load) begin
			entry_q.entry_index <= rd_idx_q;
			{entry_q.entry_red, entry_q.entry_green, entry_q.entry_blue} <=
				rd_oor_q ? '0 : ram_rdata;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

### hw/rtl/palette_keypoint_ramp_fill_top.sv
// Palette keypoint ramp fill: an RGB palette built from colour keypoints,
// with linear ramps between them, read one entry per transaction.
//
// Channels: req (sink) carries op, key_index and the keypoint colour; rsp
// (source) carries entry_index and the stored colour, one per read.
// A keypoint at or past PALETTE_DEPTH is ignored; one below the previous
// index writes nothing but becomes the new previous keypoint. Otherwise
// S_WR_P and S_WR_J write both end entries; with a gap, a shared restoring
// divider works out the slope for each channel in turn, then the ramp unit
// writes one entry per cycle. The palette
// RAM write port sets the fill rate.
// A read loads its result into the output register from S_READ, which waits
// while an earlier result is still held; req.ready is low from acceptance
// until the result sits in the output register.
// A result held by a low rsp.ready does not stop acceptance by itself, but a
// read behind it waits in S_READ and no transaction is taken meanwhile. Reset
// clears the previous keypoint to index 0, black, and empties the output
// register; palette contents stay undefined until written.
// Depends on pkrf_pkg, pkrf_if, pkrf_ram, pkrf_ctrl and pkrf_dp.
`default_nettype none

module palette_keypoint_ramp_fill_top #(
	parameter int unsigned PALETTE_DEPTH = pkrf_pkg::PALETTE_DEPTH
) (
	input wire logic     clk,
	input wire logic     arst_n,
	pkrf_key_if.sink     req,
	pkrf_entry_if.source rsp
);

	pkrf_pkg::cmd_t        cmd;
	pkrf_pkg::sts_t        sts;
	pkrf_pkg::entry_item_t entry;

	pkrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_op   (req.data.op),
		.rsp_ready(rsp.ready),
		.sts      (sts),
		.cmd      (cmd),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid)
	);

	pkrf_dp #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.key   (req.data),
		.sts   (sts),
		.entry (entry)
	);

	assign rsp.data = entry;

`ifndef ASSERT_OFF
	a_wr_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_p, cmd.wr_j, cmd.fill_step}))
		else $error("palette write port driven by more than one source");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_p || cmd.wr_j || cmd.div_step || cmd.fill_step) |-> !req.ready)
		else $error("transaction accepted while a keypoint is in progress");

	a_fill_contig: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fill_step && !sts.fill_last) |=> cmd.fill_step)
		else $error("ramp fill interrupted");

	a_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.data.op == pkrf_pkg::OP_READ) |=> !req.ready)
		else $error("transaction accepted before read result was loaded");
`endif

endmodule

`default_nettype wire

### sim/tb_top.sv
// Testbench for palette_keypoint_ramp_fill_top: directed table plus random keypoint
// ramps and entry reads, checked against a palette shadow model.
// Depends on pkrf_pkg, pkrf_if and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
	import pkrf_pkg::*;

	localparam int unsigned RANDOM_ITEMS   = 400;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES  = 300;
	localparam int unsigned MAX_PRINTS     = 50;

	typedef struct {
		logic                op;
		logic [IDX_W-1:0]   idx;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		bit                  typed;
		logic [COLOR_W-1:0] want_red;
		logic [COLOR_W-1:0] want_green;
		logic [COLOR_W-1:0] want_blue;
	} stim_row_t;

	logic clk;
	logic arst_n = 1'b0;

	pkrf_key_if   req_if();
	pkrf_entry_if rsp_if();

	palette_keypoint_ramp_fill_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	logic [RGB_W-1:0] shadow_palette [PALETTE_DEPTH];
	bit               shadow_written [PALETTE_DEPTH];
	int unsigned      last_key_index = 0;
	logic [RGB_W-1:0] last_key_color = '0;
	entry_item_t      pending_entries [$];
	int unsigned      error_count = 0;
	int unsigned      idle_cycles = 0;
	bit               quiet = 1'b0;
	stim_row_t        stim_table [24];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [COLOR_W-1:0] ramp_level(input logic [COLOR_W-1:0] s,
			input logic [COLOR_W-1:0] e, input int unsigned k, input int unsigned span);
		int num;
		int den;
		num = (2 * int'(s) + 1) * int'(span) + 2 * (int'(e) - int'(s)) * int'(k);
		den = 2 * int'(span);
		return COLOR_W'(num / den);
	endfunction

	function automatic void apply_keypoint(input key_item_t it);
		logic [RGB_W-1:0] c;
		int unsigned      p;
		int unsigned      j;
		c = {it.key_red, it.key_green, it.key_blue};
		p = last_key_index;
		j = it.key_index;
		if (j >= PALETTE_DEPTH)
			return;
		if (p <= j) begin
			shadow_palette[p] = last_key_color;
			shadow_palette[j] = c;
			shadow_written[p] = 1'b1;
			shadow_written[j] = 1'b1;
			for (int unsigned i = p + 1; i < j; i++) begin
				shadow_palette[i] = {
					ramp_level(last_key_color[23:16], c[23:16], i - p, j - p),
					ramp_level(last_key_color[15:8], c[15:8], i - p, j - p),
					ramp_level(last_key_color[7:0], c[7:0], i - p, j - p)};
				shadow_written[i] = 1'b1;
			end
		end
		last_key_index = j;
		last_key_color = c;
	endfunction

	function automatic key_item_t random_item(input logic op, input int unsigned idx);
		key_item_t it;
		it.op        = op;
		it.key_index = IDX_W'(idx);
		it.key_red   = COLOR_W'($urandom_range(0, 255));
		it.key_green = COLOR_W'($urandom_range(0, 255));
		it.key_blue  = COLOR_W'($urandom_range(0, 255));
		return it;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// Hold valid/data until taken, then update the shadow or queue the expected read entry.
	task automatic drive_item(input key_item_t it, input bit typed = 1'b0,
			input entry_item_t want = '0);
		int unsigned gap;
		entry_item_t exp;
		gap = quiet ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= it;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		if (it.op == OP_READ) begin
			if (typed) begin
				exp = want;
			end else begin
				exp.entry_index = it.key_index;
				{exp.entry_red, exp.entry_green, exp.entry_blue} =
					(it.key_index < PALETTE_DEPTH) ? shadow_palette[it.key_index] : '0;
			end
			pending_entries.push_back(exp);
		end else begin
			apply_keypoint(it);
		end
	endtask

	task automatic drain_entries();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (pending_entries.size() != 0);
	endtask

	initial begin
		int unsigned stall;
		rsp_if.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 11);
			if (stall != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_if.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		entry_item_t want;
		if (rsp_if.valid && rsp_if.ready) begin
			if (pending_entries.size() == 0) begin
				report_mismatch($sformatf("unexpected entry %0d", rsp_if.data.entry_index));
			end else begin
				want = pending_entries.pop_front();
				check_field("entry_index", rsp_if.data.entry_index, want.entry_index);
				check_field("entry_red", rsp_if.data.entry_red, want.entry_red);
				check_field("entry_green", rsp_if.data.entry_green, want.entry_green);
				check_field("entry_blue", rsp_if.data.entry_blue, want.entry_blue);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		key_item_t   it;
		entry_item_t want;
		int unsigned sent;
		int unsigned idx;
		int unsigned lo;
		int unsigned steps;
		int unsigned reads;
		bit          drained;

		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		sent    = 0;
		drained = 1'b0;
		foreach (shadow_written[n])
			shadow_written[n] = 1'b0;

		stim_table = '{
			'{OP_KEY,  8'd0,   8'd255, 8'd0,   8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_READ, 8'd0,   8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd128},
			'{OP_KEY,  8'd1,   8'd0,   8'd255, 8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_READ, 8'd1,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd255, 8'd1},
			'{OP_READ, 8'd0,   8'd170, 8'd85,  8'd170, 1'b1, 8'd255, 8'd0,   8'd128},
			'{OP_KEY,  8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_READ, 8'd255, 8'd0,   8'd0,   8'd0,   1'b1, 8'd255, 8'd255, 8'd255},
			'{OP_READ, 8'd128, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_READ, 8'd2,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_READ, 8'd254, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_KEY,  8'd10,  8'd1,   8'd2,   8'd3,   1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_READ, 8'd10,  8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_KEY,  8'd10,  8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_READ, 8'd10,  8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
			'{OP_KEY,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_KEY,  8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_READ, 8'd127, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_READ, 8'd128, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_KEY,  8'd3,   8'd255, 8'd0,   8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_KEY,  8'd6,   8'd0,   8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_READ, 8'd4,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_READ, 8'd5,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
			'{OP_READ, 8'd6,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd255, 8'd0},
			'{OP_READ, 8'd3,   8'd0,   8'd0,   8'd0,   1'b1, 8'd255, 8'd0,   8'd255}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[n]) begin
			it.op        = stim_table[n].op;
			it.key_index = stim_table[n].idx;
			it.key_red   = stim_table[n].red;
			it.key_green = stim_table[n].green;
			it.key_blue  = stim_table[n].blue;
			want.entry_index = stim_table[n].idx;
			want.entry_red   = stim_table[n].want_red;
			want.entry_green = stim_table[n].want_green;
			want.entry_blue  = stim_table[n].want_blue;
			drive_item(it, stim_table[n].typed, want);
		end
		drain_entries();

		while (sent < RANDOM_ITEMS) begin
			if (!drained && sent >= RANDOM_ITEMS / 2) begin
				drain_entries();
				drained = 1'b1;
			end
			if ($urandom_range(0, 5) == 0)
				quiet = !quiet;
			if ($urandom_range(0, 9) < 7) begin
				// ramp: a start key, keys that do not fall, then reads inside the ramp
				lo = $urandom_range(0, 255);
				drive_item(random_item(OP_KEY, lo));
				idx   = lo;
				steps = $urandom_range(1, 4);
				reads = $urandom_range(1, 4);
				repeat (steps) begin
					case ($urandom_range(0, 19))
						0:          idx += $urandom_range(41, 255);
						1, 2, 3, 4: idx += $urandom_range(9, 40);
						default:    idx += $urandom_range(0, 8);
					endcase
					if (idx > 255)
						idx = 255;
					drive_item(random_item(OP_KEY, idx));
				end
				repeat (reads)
					drive_item(random_item(OP_READ, $urandom_range(idx, lo)));
				sent += 1 + steps + reads;
			end else begin
				if ($urandom_range(0, 1) == 0) begin
					drive_item(random_item(OP_KEY, $urandom_range(0, 255)));
				end else begin
					do idx = $urandom_range(0, 255); while (!shadow_written[idx]);
					drive_item(random_item(OP_READ, idx));
				end
				sent++;
			end
		end

		drain_entries();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_entries.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
